[sv/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ssqe_pkg.sv]
// types, constants and codes of the sorted set query engine
package ssqe_pkg;

    localparam int CAPACITY    = 256;
    localparam int OP_W        = 3;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 3;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int TREE_LEAVES = (CAPACITY < 2) ? 2 : (1 << $clog2(CAPACITY));
    localparam int TREE_DEPTH  = $clog2(TREE_LEAVES);
    localparam int NODE_CNT    = TREE_LEAVES - 1;
    localparam int WAIT_W      = $clog2(TREE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_MIN    = 3'd2,
        OP_MAX    = 3'd3,
        OP_GT     = 3'd4,
        OP_GE     = 3'd5,
        OP_LT     = 3'd6,
        OP_LE     = 3'd7
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 3'd0,
        STAT_FOUND = 3'd1,
        STAT_EMPTY = 3'd2,
        STAT_NONE  = 3'd3,
        STAT_FULL  = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                    lt;
        logic                    le;
        logic signed [VAL_W-1:0] value;
    } cell_link_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        opcode_t                 op;
        logic signed [VAL_W-1:0] value;
        logic                    ins;
        logic                    del;
    } cell_ctl_t;

    // latched command
    typedef struct packed {
        opcode_t                 op;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

endpackage

[sv/ssqe_cmd_if.sv]
// command channel: opcode and operand value
interface ssqe_cmd_if import ssqe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

[sv/ssqe_rsp_if.sv]
// result channel: status and found element
interface ssqe_rsp_if import ssqe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

[sv/ssqe_cell.sv]
// one slot of the sorted row: holds an element, compares, shifts with its neighbors
module ssqe_cell import ssqe_pkg::*;
(
    input  logic       clk,
    input  cell_ctl_t  ctl,
    input  logic       occ,
    input  logic       occ_prev,
    input  logic       occ_next,
    input  cell_link_t prev,
    input  cell_link_t next,
    output cell_link_t link,
    output logic       hit
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    lt;
    logic                    le;

    // compare against the broadcast operand, empty slots never count as below
    assign lt = occ && (val_reg < ctl.value);
    assign le = occ && (val_reg <= ctl.value);

    assign link.lt    = lt;
    assign link.le    = le;
    assign link.value = val_reg;

    // local match for the current opcode, at most one cell in the row matches
    always_comb
    begin
        hit = 1'b0;
        unique case (ctl.op) inside
            OP_INSERT, OP_ERASE: hit = occ && (val_reg == ctl.value);
            OP_MIN:              hit = occ && !occ_prev;
            OP_MAX:              hit = occ && !occ_next;
            OP_GT:               hit = occ && !le && prev.le;
            OP_GE:               hit = occ && !lt && prev.lt;
            OP_LT:               hit = lt && !next.lt;
            OP_LE:               hit = le && !next.le;
        endcase
    end

    // shift right to open a gap on insert, shift left to close it on erase
    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins && !lt)
        begin
            val_next = prev.lt ? ctl.value : prev.value;
        end
        else if (ctl.del && !lt)
        begin
            val_next = next.value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[sv/ssqe_tree.sv]
// registered or-tree that collects the single matching cell
module ssqe_tree import ssqe_pkg::*;
(
    input  logic                    clk,
    input  logic                    leaf_hit [CAPACITY],
    input  logic signed [VAL_W-1:0] leaf_val [CAPACITY],
    output logic                    root_hit,
    output logic signed [VAL_W-1:0] root_val
);

    logic             kid_hit [2*TREE_LEAVES-1];
    logic [VAL_W-1:0] kid_val [2*TREE_LEAVES-1];
    logic             node_hit_reg [NODE_CNT];
    logic [VAL_W-1:0] node_val_reg [NODE_CNT];

    // heap layout: node n has children 2n+1 and 2n+2, leaves at the bottom
    for (genvar n = 0; n < 2*TREE_LEAVES-1; n++)
    begin : g_node
        if (n < NODE_CNT)
        begin : g_inner
            assign kid_hit[n] = node_hit_reg[n];
            assign kid_val[n] = node_val_reg[n];

            always_ff @(posedge clk)
            begin
                node_hit_reg[n] <= kid_hit[2*n+1] | kid_hit[2*n+2];
                node_val_reg[n] <= kid_val[2*n+1] | kid_val[2*n+2];
            end
        end
        else if (n - NODE_CNT < CAPACITY)
        begin : g_leaf
            assign kid_hit[n] = leaf_hit[n-NODE_CNT];
            assign kid_val[n] = leaf_hit[n-NODE_CNT] ? leaf_val[n-NODE_CNT] : '0;
        end
        else
        begin : g_pad
            assign kid_hit[n] = 1'b0;
            assign kid_val[n] = '0;
        end
    end

    assign root_hit = kid_hit[0];
    assign root_val = kid_val[0];

endmodule

[sv/sorted_set_query_engine.sv]
// sorted set query engine top level: controller, cell row and result tree
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order in a row
// of cells, one value per cell. A command runs from its accept through the
// registered or-tree, which brings the single matching cell to the controller
// in log2 of the row length (rounded up) stages, to the commit and the result
// load, and a new command is accepted once the previous one has been committed
// to the row. Insert and erase shift the cells from the affected position onward
// by one cell in the commit cycle. The store needs no clearing after reset. A
// result beat may wait at the output while the next command is accepted.
`include "assert_macros.svh"

module sorted_set_query_engine import ssqe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ssqe_cmd_if.sink   cmd,
    ssqe_rsp_if.source rsp
);

    state_t                  state_reg;
    state_t                  state_next;
    logic [WAIT_W-1:0]       wait_reg;
    logic [WAIT_W-1:0]       wait_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    cmd_t                    cmd_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    status_t                 rsp_status_reg;
    status_t                 rsp_status_next;
    logic signed [VAL_W-1:0] rsp_value_reg;
    logic signed [VAL_W-1:0] rsp_value_next;
    logic                    rsp_load;
    logic                    ins;
    logic                    del;
    logic                    cmd_accept;

    cell_ctl_t               ctl;
    logic                    occ       [CAPACITY];
    cell_link_t              links     [CAPACITY];
    logic                    leaf_hit  [CAPACITY];
    logic signed [VAL_W-1:0] leaf_val  [CAPACITY];
    logic                    root_hit;
    logic signed [VAL_W-1:0] root_val;

    localparam cell_link_t LEFT_EDGE  = '{lt: 1'b1, le: 1'b1, value: '0};
    localparam cell_link_t RIGHT_EDGE = '{lt: 1'b0, le: 1'b0, value: '0};

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_accept = cmd.valid && (state_reg == S_IDLE);

    assign ctl.op    = cmd_reg.op;
    assign ctl.value = cmd_reg.value;
    assign ctl.ins   = ins;
    assign ctl.del   = del;

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_link_t prev_link;
        cell_link_t next_link;
        logic       occ_prev;
        logic       occ_next;

        assign occ[i] = (cnt_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign prev_link = LEFT_EDGE;
            assign occ_prev  = 1'b0;
        end
        else
        begin : g_mid_l
            assign prev_link = links[i-1];
            assign occ_prev  = occ[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_link = RIGHT_EDGE;
            assign occ_next  = 1'b0;
        end
        else
        begin : g_mid_r
            assign next_link = links[i+1];
            assign occ_next  = occ[i+1];
        end

        ssqe_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .occ      (occ[i]),
            .occ_prev (occ_prev),
            .occ_next (occ_next),
            .prev     (prev_link),
            .next     (next_link),
            .link     (links[i]),
            .hit      (leaf_hit[i])
        );

        assign leaf_val[i] = links[i].value;
    end

    // match collection
    ssqe_tree u_tree (
        .clk      (clk),
        .leaf_hit (leaf_hit),
        .leaf_val (leaf_val),
        .root_hit (root_hit),
        .root_val (root_val)
    );

    // controller: wait for the tree, then commit and load the result
    always_comb
    begin
        state_next      = state_reg;
        wait_next       = wait_reg;
        cnt_next        = cnt_reg;
        ins             = 1'b0;
        del             = 1'b0;
        rsp_load        = 1'b0;
        rsp_status_next = STAT_DONE;
        rsp_value_next  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_SEARCH;
                    wait_next  = WAIT_W'(TREE_DEPTH);
                end
            end
            S_SEARCH:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - 1'b1;
                end
                else if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                    case (cmd_reg.op) inside
                        OP_INSERT:
                        begin
                            if (root_hit)
                            begin
                                rsp_status_next = STAT_DONE;
                            end
                            else if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                rsp_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ins      = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (root_hit)
                            begin
                                del      = 1'b1;
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        OP_MIN, OP_MAX, OP_GT, OP_GE, OP_LT, OP_LE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_status_next = STAT_EMPTY;
                            end
                            else if (root_hit)
                            begin
                                rsp_status_next = STAT_FOUND;
                                rsp_value_next  = root_val;
                            end
                            else
                            begin
                                rsp_status_next = STAT_NONE;
                            end
                        end
                        default:
                        begin
                            rsp_status_next = STAT_DONE;
                        end
                    endcase
                end
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            cmd_reg.op    <= opcode_t'(cmd.opcode);
            cmd_reg.value <= cmd.value;
        end
        if (rsp_load)
        begin
            rsp_status_reg <= rsp_status_next;
            rsp_value_reg  <= rsp_value_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.result_value = rsp_value_reg;

    // checks
    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(CAPACITY))
    `ASSERT_NEXT(a_cnt_only_on_commit, clk, rst_n, !(ins || del), $stable(cnt_reg))
    `ASSERT_IMPLIES(a_full_drop, clk, rst_n, rsp_load && rsp_status_next == STAT_FULL, cnt_reg == CNT_W'(CAPACITY) && !ins)
    `ASSERT_IMPLIES(a_value_zero, clk, rst_n, rsp.valid && rsp.status != STAT_FOUND, rsp.result_value == '0)

endmodule

[sim/sorted_set_query_engine_test.sv]
`timescale 1ns / 1ps
// testbench of the sorted set query engine: directed and random commands against a set predictor
module sorted_set_query_engine_test import ssqe_pkg::*; ();

    typedef logic signed [VAL_W-1:0] elem_t;

    // one expected result beat
    typedef struct {
        status_t status;
        elem_t   value;
    } set_reply_t;

    localparam elem_t MIN_VAL     = elem_t'(32'h8000_0000);
    localparam elem_t MAX_VAL     = elem_t'(32'h7fff_ffff);
    localparam int    RSP_LATENCY = TREE_DEPTH + 2;

    logic clk;
    logic rst_n;

    ssqe_cmd_if cmd ();
    ssqe_rsp_if rsp ();

    elem_t      set_elems [$];        // ascending contents of the predicted set
    set_reply_t pending_results [$];  // replies still owed by the block
    int         fail_count;
    bit         src_idle_on;
    bit         sink_idle_on;

    sorted_set_query_engine u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // first index whose element is >= v, or > v when strict
    function automatic int first_index(elem_t v, bit strict);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = set_elems.size();
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (set_elems[mid] <= v) : (set_elems[mid] < v))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // apply one command to the predicted set and return its reply
    function automatic set_reply_t apply_command(opcode_t op, elem_t v);
        set_reply_t r;
        int         pos;
        r.status = STAT_DONE;
        r.value  = '0;
        case (op)
            OP_INSERT:
            begin
                pos = first_index(v, 1'b0);
                if (pos < set_elems.size() && set_elems[pos] == v)
                    r.status = STAT_DONE;
                else if (set_elems.size() >= CAPACITY)
                    r.status = STAT_FULL;
                else
                    set_elems.insert(pos, v);
            end
            OP_ERASE:
            begin
                pos = first_index(v, 1'b0);
                if (pos < set_elems.size() && set_elems[pos] == v)
                    set_elems.delete(pos);
            end
            default:
            begin
                if (set_elems.size() == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    case (op)
                        OP_MIN:  pos = 0;
                        OP_MAX:  pos = set_elems.size() - 1;
                        OP_GT:   pos = first_index(v, 1'b1);
                        OP_GE:   pos = first_index(v, 1'b0);
                        OP_LT:   pos = first_index(v, 1'b0) - 1;
                        default: pos = first_index(v, 1'b1) - 1;
                    endcase
                    if (pos >= 0 && pos < set_elems.size())
                    begin
                        r.status = STAT_FOUND;
                        r.value  = set_elems[pos];
                    end
                    else
                        r.status = STAT_NONE;
                end
            end
        endcase
        return r;
    endfunction

    // operand mix: small range, near members, extremes, anything
    function automatic elem_t pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return elem_t'(int'($urandom_range(0, 63)) - 32);
        else if (roll < 60 && set_elems.size() != 0)
            return set_elems[$urandom_range(0, set_elems.size() - 1)]
                   + elem_t'(int'($urandom_range(0, 2)) - 1);
        else if (roll < 75)
        begin
            case ($urandom_range(0, 5))
                0:       return MIN_VAL;
                1:       return MIN_VAL + 1;
                2:       return MAX_VAL;
                3:       return MAX_VAL - 1;
                4:       return '0;
                default: return -1;
            endcase
        end
        return elem_t'($urandom);
    endfunction

    function automatic opcode_t pick_query();
        return opcode_t'($urandom_range(OP_MIN, OP_LE));
    endfunction

    function automatic void flag_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // send one command beat and record its expected reply
    task automatic send_command(input opcode_t op, input elem_t v);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid  <= 1'b1;
        cmd.opcode <= op;
        cmd.value  <= v;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        pending_results.push_back(apply_command(op, v));
    endtask

    // result sink with random stalls
    initial
    begin : rsp_sink
        int hold;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = sink_idle_on ? $urandom_range(0, 11) : 0;
            if (hold > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp.valid !== 1'b1);
        end
    end

    // compare every result beat with the oldest expected reply
    always @(posedge clk)
    begin
        set_reply_t want;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                flag_failure($sformatf("unexpected result beat: status %0d value %0d",
                                       rsp.status, rsp.result_value));
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.result_value !== want.value)
                    flag_failure($sformatf(
                        "result mismatch: status exp %0d got %0d, value exp %0d got %0d",
                        want.status, rsp.status, want.value, rsp.result_value));
            end
        end
    end

    // every query on an empty set, and erase of an absent value
    task automatic test_empty_set();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_command(OP_MIN, '0);
        send_command(OP_MAX, '0);
        send_command(OP_GT, MAX_VAL);
        send_command(OP_GE, MIN_VAL);
        send_command(OP_LT, MIN_VAL);
        send_command(OP_LE, MAX_VAL);
        send_command(OP_ERASE, 7);
    endtask

    // extremes, duplicates and strict / non-strict bounds at the ends
    task automatic test_bounds();
        send_command(OP_INSERT, MAX_VAL);
        send_command(OP_INSERT, MIN_VAL);
        send_command(OP_INSERT, '0);
        send_command(OP_INSERT, '0);
        send_command(OP_ERASE, 5);
        send_command(OP_MIN, 3);
        send_command(OP_MAX, -3);
        send_command(OP_GT, MAX_VAL);
        send_command(OP_GE, MAX_VAL);
        send_command(OP_LT, MIN_VAL);
        send_command(OP_LE, MIN_VAL);
        send_command(OP_GT, '0);
        send_command(OP_LT, '0);
        send_command(OP_GE, 1);
        send_command(OP_LE, -1);
        send_command(OP_ERASE, '0);
        send_command(OP_GE, '0);
        send_command(OP_LE, '0);
    endtask

    // random mix of updates and queries, idling switched per stretch
    task automatic test_mixed_traffic(input int count);
        int      roll;
        opcode_t op;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
            begin
                src_idle_on  = 1'($urandom_range(0, 1));
                sink_idle_on = 1'($urandom_range(0, 1));
            end
            roll = $urandom_range(0, 99);
            if (roll < 35)
                op = OP_INSERT;
            else if (roll < 55)
                op = OP_ERASE;
            else
                op = pick_query();
            send_command(op, pick_value());
        end
    endtask

    // back-to-back inserts, with an occasional query, until the store holds CAPACITY values
    task automatic test_fill_to_capacity();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (set_elems.size() < CAPACITY)
        begin
            if ($urandom_range(0, 7) == 0)
                send_command(pick_query(), pick_value());
            else
                send_command(OP_INSERT, elem_t'($urandom));
        end
    endtask

    // new inserts dropped when full, duplicates still accepted
    task automatic test_full_store(input int count);
        int roll;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                send_command(OP_INSERT, elem_t'($urandom));
            else if (roll < 45)
                send_command(OP_INSERT, set_elems[$urandom_range(0, set_elems.size() - 1)]);
            else if (roll < 55)
            begin
                // free one slot and take it again
                send_command(OP_ERASE, set_elems[$urandom_range(0, set_elems.size() - 1)]);
                send_command(OP_INSERT, elem_t'($urandom));
            end
            else if (roll < 62)
                send_command(OP_INSERT, pick_value());
            else
                send_command(pick_query(), pick_value());
        end
    endtask

    // erase members until the set is empty, then query it
    task automatic test_drain_to_empty();
        int roll;
        int n;
        n = 0;
        while (set_elems.size() > 0)
        begin
            if (n % 48 == 0)
            begin
                src_idle_on  = 1'($urandom_range(0, 1));
                sink_idle_on = 1'($urandom_range(0, 1));
            end
            n++;
            roll = $urandom_range(0, 99);
            if (roll < 15)
                send_command(pick_query(), pick_value());
            else if (roll < 22)
                send_command(OP_ERASE, pick_value());
            else
                send_command(OP_ERASE, set_elems[$urandom_range(0, set_elems.size() - 1)]);
        end
        for (int i = 0; i < 6; i++)
            send_command(pick_query(), pick_value());
    endtask

    // main sequence
    initial
    begin
        fail_count   = 0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        rst_n        = 1'b0;
        cmd.valid  <= 1'b0;
        cmd.opcode <= OP_INSERT;
        cmd.value  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set();
        test_bounds();
        test_mixed_traffic(500);
        test_fill_to_capacity();
        test_full_store(80);
        test_drain_to_empty();
        test_mixed_traffic(300);
        cmd.valid <= 1'b0;

        // let the last beats drain, then watch for stray ones
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * RSP_LATENCY) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
